// File: rtl/pif_pkg.sv
`timescale 1ns / 1ps

package pif_pkg;

  // request kinds on the input stream (tuser)
  localparam logic [1:0] CMD_RECT   = 2'd0;
  localparam logic [1:0] CMD_CIRCLE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam int CMD_W   = 2;
  localparam int POINT_W = 16;  // running query number

  // controller -> datapath
  typedef struct packed {
    logic store;         // append figure from the input request
    logic store_circle;  // appended figure is a circle
    logic start;         // latch query point
    logic issue;         // read table entry at addr
    logic finish;        // close the query with its last result
  } pif_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;   // pipe may move this cycle
    logic busy;  // compare pipe holds entries
    logic full;  // table at capacity
  } pif_stat_t;

endpackage

// File: rtl/pif_ctrl.sv
`timescale 1ns / 1ps

module pif_ctrl #(
  parameter int MAX_FIGURES = 16,
  localparam int IdxW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1,
  localparam int CntW = $clog2(MAX_FIGURES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pif_pkg::CMD_W-1:0]  kind_i,
  input  pif_pkg::pif_stat_t         stat_i,
  input  logic [CntW-1:0]            fig_cnt_i,
  output logic                       ready_o,
  output pif_pkg::pif_cmd_t          cmd_o,
  output logic [IdxW-1:0]            addr_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;

  assign ready_o = (state_q == ST_IDLE);
  assign accept  = valid_i && ready_o;
  assign addr_o  = idx_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            pif_pkg::CMD_RECT: begin
              cmd_o.store = !stat_i.full;
            end
            pif_pkg::CMD_CIRCLE: begin
              cmd_o.store        = !stat_i.full;
              cmd_o.store_circle = 1'b1;
            end
            pif_pkg::CMD_QUERY: begin
              cmd_o.start = 1'b1;
              idx_d       = '0;
              state_d     = (fig_cnt_i == '0) ? ST_FINAL : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.adv) begin
          cmd_o.issue = 1'b1;
          if (CntW'(idx_q) + CntW'(1) == fig_cnt_i) begin
            state_d = ST_DRAIN;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat_i.adv) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: rtl/pif_datapath.sv
`timescale 1ns / 1ps

module pif_datapath #(
  parameter int MAX_FIGURES = 16,
  parameter int COORD_WIDTH = 24,
  localparam int IdxW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1,
  localparam int CntW = $clog2(MAX_FIGURES + 1),
  localparam int CW   = COORD_WIDTH,
  localparam int InW  = ((9 * COORD_WIDTH - 1 + 7) / 8) * 8,
  localparam int OutW = ((pif_pkg::POINT_W + CntW + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pif_pkg::pif_cmd_t  cmd_i,
  input  logic [IdxW-1:0]    addr_i,
  input  logic [InW-1:0]     in_data_i,
  input  logic               out_ready_i,
  output pif_pkg::pif_stat_t stat_o,
  output logic [CntW-1:0]    fig_cnt_o,
  output logic               out_valid_o,
  output logic [OutW-1:0]    out_data_o,
  output logic               out_user_o,
  output logic               out_last_o
);

  localparam int EntW = 1 + 4 * CW;

  // entry layout {is_circle, a, b, c, d}
  logic [EntW-1:0] fig_mem_q [MAX_FIGURES];
  logic [EntW-1:0] entry;

  logic [CntW-1:0] fig_cnt_q;
  logic [pif_pkg::POINT_W-1:0] qcnt_q;

  logic signed [CW-1:0] px_q, py_q;

  logic adv, busy;

  // read stage
  logic            v_rd_q;
  logic [EntW-1:0] rd_q;
  logic [IdxW-1:0] rd_idx_q;
  logic                 rd_circ;
  logic signed [CW-1:0] rd_a, rd_b, rd_c, rd_d;
  logic signed [CW:0]   dxs, dys;

  // difference stage
  logic            v_s1_q;
  logic [CW:0]     s1_dx_q, s1_dy_q;
  logic [CW-2:0]   s1_r_q;
  logic            s1_circ_q, s1_rect_q;
  logic [IdxW-1:0] s1_idx_q;

  // square stage
  logic              v_s2_q;
  logic [2*CW+1:0]   s2_dx2_q, s2_dy2_q;
  logic [2*CW-3:0]   s2_r2_q;
  logic              s2_circ_q, s2_rect_q;
  logic [IdxW-1:0]   s2_idx_q;
  logic [2*CW+2:0]   s2_sum;
  logic              s2_hit;

  logic            hit_take, hit_emit;
  logic            pend_valid_q;
  logic [CntW-1:0] pend_fig_q;

  logic                        out_valid_q;
  logic [CntW-1:0]             out_fig_q;
  logic [pif_pkg::POINT_W-1:0] out_num_q;
  logic                        out_cont_q, out_last_q;

  // request fields, lowest first
  always_comb begin
    if (cmd_i.store_circle) begin
      entry = {1'b1, in_data_i[5*CW-1:4*CW], in_data_i[6*CW-1:5*CW],
               1'b0, in_data_i[7*CW-2:6*CW], {CW{1'b0}}};
    end else begin
      entry = {1'b0, in_data_i[CW-1:0], in_data_i[2*CW-1:CW],
               in_data_i[3*CW-1:2*CW], in_data_i[4*CW-1:3*CW]};
    end
  end

  assign adv  = !out_valid_q || out_ready_i;
  assign busy = v_rd_q || v_s1_q || v_s2_q;

  assign stat_o.adv  = adv;
  assign stat_o.busy = busy;
  assign stat_o.full = (fig_cnt_q == CntW'(MAX_FIGURES));
  assign fig_cnt_o   = fig_cnt_q;

  // figure table
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      fig_mem_q[fig_cnt_q[IdxW-1:0]] <= entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd_i.issue) begin
      rd_q     <= fig_mem_q[addr_i];
      rd_idx_q <= addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_data_i[8*CW-2:7*CW-1];
      py_q <= in_data_i[9*CW-2:8*CW-1];
    end
  end

  assign rd_circ = rd_q[EntW-1];
  assign rd_a    = rd_q[4*CW-1:3*CW];
  assign rd_b    = rd_q[3*CW-1:2*CW];
  assign rd_c    = rd_q[2*CW-1:CW];
  assign rd_d    = rd_q[CW-1:0];

  assign dxs = {px_q[CW-1], px_q} - {rd_a[CW-1], rd_a};
  assign dys = {py_q[CW-1], py_q} - {rd_b[CW-1], rd_b};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dx_q   <= dxs[CW] ? -dxs : dxs;
      s1_dy_q   <= dys[CW] ? -dys : dys;
      s1_r_q    <= rd_c[CW-2:0];
      s1_circ_q <= rd_circ;
      s1_rect_q <= (px_q > rd_a) && (px_q < rd_c) && (py_q > rd_d) && (py_q < rd_b);
      s1_idx_q  <= rd_idx_q;

      s2_dx2_q  <= s1_dx_q * s1_dx_q;
      s2_dy2_q  <= s1_dy_q * s1_dy_q;
      s2_r2_q   <= s1_r_q * s1_r_q;
      s2_circ_q <= s1_circ_q;
      s2_rect_q <= s1_rect_q;
      s2_idx_q  <= s1_idx_q;
    end
  end

  assign s2_sum = {1'b0, s2_dx2_q} + {1'b0, s2_dy2_q};
  assign s2_hit = s2_circ_q ? (s2_sum < (2*CW+3)'(s2_r2_q)) : s2_rect_q;

  // a hit is held back one step so the final one can carry last
  assign hit_take = adv && v_s2_q && s2_hit;
  assign hit_emit = hit_take && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fig_cnt_q    <= '0;
      qcnt_q       <= pif_pkg::POINT_W'(1);
      v_rd_q       <= 1'b0;
      v_s1_q       <= 1'b0;
      v_s2_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        fig_cnt_q <= fig_cnt_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        qcnt_q <= (qcnt_q == '1) ? pif_pkg::POINT_W'(1) : qcnt_q + pif_pkg::POINT_W'(1);
      end
      if (adv) begin
        v_rd_q      <= cmd_i.issue;
        v_s1_q      <= v_rd_q;
        v_s2_q      <= v_s1_q;
        out_valid_q <= hit_emit || cmd_i.finish;
      end
      if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end else if (hit_take) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_take) begin
      pend_fig_q <= CntW'(s2_idx_q) + CntW'(1);
    end
    if (hit_emit) begin
      out_fig_q  <= pend_fig_q;
      out_num_q  <= qcnt_q;
      out_cont_q <= 1'b1;
      out_last_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_fig_q  <= pend_valid_q ? pend_fig_q : '0;
      out_num_q  <= qcnt_q;
      out_cont_q <= pend_valid_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OutW'({out_fig_q, out_num_q});
  assign out_user_o  = out_cont_q;
  assign out_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (adv && !busy))
    else $error("query closed with compares in flight");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> (!busy && !pend_valid_q))
    else $error("query started over a previous one");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (fig_cnt_q < CntW'(MAX_FIGURES)))
    else $error("figure stored into a full table");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fig_cnt_q <= CntW'(MAX_FIGURES)) && (qcnt_q != '0))
    else $error("figure count or query number out of range");
`endif

endmodule

// File: rtl/point_in_figures_hit_test.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                               tuser      tlast
// s_axis   in   left top right bottom cx cy radius px py (zero pad) cmd     -
// m_axis   out  point_number figure_number (zero pad)            contained  last
//
// Loads keep ready high; loads past a full table are dropped.
// A query over N >= 1 figures keeps ready low through N table reads, one per cycle
// through the single read port unless the output stalls, the emptying of the read /
// difference / square stages, a drain state that waits to see them empty, and a final
// state writing the closing result; an empty table skips straight to that state.
// Reset clears the figure count and sets the query number to 1; table contents
// are not cleared and are only read below the count.
// m_axis_tready low freezes the whole compare pipe and adds its cycles to the query;
// a held result does not block the next request once the current query has closed.

module point_in_figures_hit_test #(
  parameter int MAX_FIGURES = 16,
  parameter int COORD_WIDTH = 24,
  localparam int CntW = $clog2(MAX_FIGURES + 1),
  localparam int InW  = ((9 * COORD_WIDTH - 1 + 7) / 8) * 8,
  localparam int OutW = ((pif_pkg::POINT_W + CntW + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // rect_left, rect_top, rect_right, rect_bottom, circle_x, circle_y,
  // circle_radius, point_x, point_y, zero pad
  input  logic [InW-1:0]            s_axis_tdata_i,
  // cmd
  input  logic [pif_pkg::CMD_W-1:0] s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // point_number, figure_number, zero pad
  output logic [OutW-1:0]           m_axis_tdata_o,
  // contained
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);

  localparam int IdxW = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;

  pif_pkg::pif_cmd_t  cmd;
  pif_pkg::pif_stat_t stat;
  logic [IdxW-1:0]    addr;
  logic [CntW-1:0]    fig_cnt;

  // sequencer: decodes requests, walks the table, closes each query
  pif_ctrl #(
    .MAX_FIGURES(MAX_FIGURES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .kind_i    (s_axis_tuser_i),
    .stat_i    (stat),
    .fig_cnt_i (fig_cnt),
    .ready_o   (s_axis_tready_o),
    .cmd_o     (cmd),
    .addr_o    (addr)
  );

  // table, containment pipe, pending hit and output register
  pif_datapath #(
    .MAX_FIGURES(MAX_FIGURES),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .stat_o      (stat),
    .fig_cnt_o   (fig_cnt),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
